// ----- hdl/fua_pkg.sv -----
package fua_pkg;

  localparam int unsigned MaxPayloadW = 13;
  localparam int unsigned TsStepW     = 16;
  localparam int unsigned SeqW        = 16;
  localparam int unsigned TsW         = 32;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [7:0] FuNriMask   = 8'h60;
  localparam logic [7:0] FuAType     = 8'd28;
  localparam logic [7:0] NalTypeMask = 8'h1F;
  localparam logic [7:0] FuStart     = 8'h80;
  localparam logic [7:0] FuEnd       = 8'h40;
  localparam logic [4:0] TypeSps     = 5'd7;
  localparam logic [4:0] TypePps     = 5'd8;

  localparam logic [MaxPayloadW-1:0] MaxPayloadRst = 13'd1400;
  localparam logic [TsStepW-1:0]     TsStepRst     = 16'd3600;

  typedef enum logic {
    CFG_MAX_PAYLOAD    = 1'b0,
    CFG_TIMESTAMP_STEP = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       final_b;
  } fua_slot_t;

  typedef struct packed {
    logic [1:0]           cnt;
    fua_slot_t [2:0]      slot;
    logic [SeqW-1:0]      seq;
    logic [TsW-1:0]       ts;
  } fua_bundle_t;

endpackage

// ----- hdl/fua_core.sv -----
module fua_core #(
  parameter int unsigned SIZE_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [7:0]                          nal_byte_i,
  input  logic [SIZE_BITS-1:0]                nal_size_i,
  input  logic [fua_pkg::MaxPayloadW-1:0]     max_payload_i,
  input  logic [fua_pkg::TsStepW-1:0]         ts_step_i,
  output fua_pkg::fua_bundle_t                bundle_o
);

  localparam int unsigned CW =
    ((SIZE_BITS > fua_pkg::MaxPayloadW) ? SIZE_BITS : fua_pkg::MaxPayloadW) + 1;

  logic [SIZE_BITS-1:0]              idx_q, idx_d;
  logic [7:0]                        held_q, held_d;
  logic                              mode_q, mode_d;
  logic [fua_pkg::MaxPayloadW-1:0]   fill_q, fill_d;
  logic [fua_pkg::SeqW-1:0]          seq_q, seq_d;
  logic [fua_pkg::TsW-1:0]           ts_q, ts_d;

  logic [SIZE_BITS-1:0]              size_w;
  logic [fua_pkg::MaxPayloadW-1:0]   limit;
  logic [CW-1:0]                     size_x, lim_x;
  logic [SIZE_BITS:0]                diff;
  logic [fua_pkg::MaxPayloadW:0]     fill_inc;
  logic                              first, unit_end, mode, closes, end_fu;
  logic [7:0]                        hdr, fu_ind, fu_hdr;
  logic [fua_pkg::MaxPayloadW-1:0]   fill;

  always_comb begin
    size_w   = (nal_size_i == '0) ? SIZE_BITS'(1) : nal_size_i;
    limit    = (max_payload_i == '0) ? fua_pkg::MaxPayloadW'(1) : max_payload_i;
    size_x   = CW'(size_w);
    lim_x    = CW'(limit);
    first    = (idx_q == '0);
    unit_end = (idx_q >= size_w - SIZE_BITS'(1));
    hdr      = first ? nal_byte_i : held_q;
    mode     = first ? (size_x > lim_x) : mode_q;
    fill     = first ? '0 : fill_q;
    fill_inc = {1'b0, fill} + (fua_pkg::MaxPayloadW+1)'(1);
    closes   = unit_end || (fill_inc >= {1'b0, limit});
    diff     = {1'b0, size_w} - {1'b0, idx_q};
    end_fu   = !diff[SIZE_BITS] && (CW'(diff[SIZE_BITS-1:0]) <= lim_x);
    fu_ind   = (hdr & fua_pkg::FuNriMask) | fua_pkg::FuAType;
    fu_hdr   = hdr & fua_pkg::NalTypeMask;
    if (idx_q == SIZE_BITS'(1)) begin
      fu_hdr = fu_hdr | fua_pkg::FuStart;
    end else if (end_fu) begin
      fu_hdr = fu_hdr | fua_pkg::FuEnd;
    end
  end

  always_comb begin
    bundle_o     = '0;
    bundle_o.seq = seq_q;
    bundle_o.ts  = ts_q;
    held_d = first ? nal_byte_i : held_q;
    mode_d = mode;
    fill_d = fill;
    seq_d  = seq_q;
    ts_d   = ts_q;
    if (!mode) begin
      bundle_o.cnt          = 2'd1;
      bundle_o.slot[0].data    = nal_byte_i;
      bundle_o.slot[0].first   = first;
      bundle_o.slot[0].final_b = unit_end;
      if (unit_end) begin
        seq_d = seq_q + fua_pkg::SeqW'(1);
        if (hdr[4:0] != fua_pkg::TypeSps && hdr[4:0] != fua_pkg::TypePps) begin
          ts_d = ts_q + fua_pkg::TsW'(ts_step_i);
        end
      end
    end else if (!first) begin
      if (fill == '0) begin
        bundle_o.cnt             = 2'd3;
        bundle_o.slot[0].data    = fu_ind;
        bundle_o.slot[0].first   = 1'b1;
        bundle_o.slot[1].data    = fu_hdr;
        bundle_o.slot[2].data    = nal_byte_i;
        bundle_o.slot[2].final_b = closes;
      end else begin
        bundle_o.cnt             = 2'd1;
        bundle_o.slot[0].data    = nal_byte_i;
        bundle_o.slot[0].final_b = closes;
      end
      if (closes) begin
        seq_d  = seq_q + fua_pkg::SeqW'(1);
        fill_d = '0;
      end else begin
        fill_d = fill_inc[fua_pkg::MaxPayloadW-1:0];
      end
      if (unit_end) begin
        ts_d = ts_q + fua_pkg::TsW'(ts_step_i);
      end
    end
    if (unit_end) begin
      idx_d  = '0;
      mode_d = 1'b0;
      fill_d = '0;
    end else begin
      idx_d = idx_q + SIZE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      held_q <= '0;
      mode_q <= 1'b0;
      fill_q <= '0;
      seq_q  <= '0;
      ts_q   <= '0;
    end else if (accept_i) begin
      idx_q  <= idx_d;
      held_q <= held_d;
      mode_q <= mode_d;
      fill_q <= fill_d;
      seq_q  <= seq_d;
      ts_q   <= ts_d;
    end
  end

endmodule

// ----- hdl/fua_emit.sv -----
module fua_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  fua_pkg::fua_bundle_t       bundle_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_first_o,
  output logic                       out_final_o,
  output logic [fua_pkg::SeqW-1:0]   out_seq_o,
  output logic [fua_pkg::TsW-1:0]    out_ts_o,
  output logic                       out_last_o
);

  fua_pkg::fua_bundle_t bun_q, bun_d;
  logic                 vld_q, vld_d;
  logic [7:0]           byte_q;
  logic                 first_q, final_q, last_q;
  logic [fua_pkg::SeqW-1:0] seq_q;
  logic [fua_pkg::TsW-1:0]  ts_q;
  logic                 out_load, take;

  assign out_load = !vld_q || out_ready_i;
  assign take     = out_load && (bun_q.cnt != 2'd0);
  assign ready_o  = (bun_q.cnt == 2'd0) || ((bun_q.cnt == 2'd1) && out_load);

  always_comb begin
    bun_d = bun_q;
    if (load_i) begin
      bun_d = bundle_i;
    end else if (take) begin
      bun_d.slot[0] = bun_q.slot[1];
      bun_d.slot[1] = bun_q.slot[2];
      bun_d.cnt     = bun_q.cnt - 2'd1;
    end
    vld_d = out_load ? (bun_q.cnt != 2'd0) : vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bun_q <= '0;
      vld_q <= 1'b0;
    end else begin
      bun_q <= bun_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= bun_q.slot[0].data;
      first_q <= bun_q.slot[0].first;
      final_q <= bun_q.slot[0].final_b;
      last_q  <= (bun_q.cnt == 2'd1);
      seq_q   <= bun_q.seq;
      ts_q    <= bun_q.ts;
    end
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_first_o = first_q;
  assign out_final_o = final_q;
  assign out_seq_o   = seq_q;
  assign out_ts_o    = ts_q;
  assign out_last_o  = last_q;

endmodule

// ----- hdl/h264_rtp_fu_a_packetizer.sv -----
// Input beats are registered in the result buffer, then in the output register.
// Throughput: one input beat per cycle, when it yields one output beat and the
// output is not stalled; a fragment start yields three output beats and holds
// the input while the three-slot result buffer drains, which sets this rate.
// Reset (rst_ni low, async) clears unit position, sequence, timestamp and
// valid flags; max_payload returns to 1400, timestamp_step to 3600.
module h264_rtp_fu_a_packetizer #(
  parameter int unsigned SIZE_BITS = 20
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // nal_byte [7:0], nal_size [SIZE_BITS+7:8], zero pad
  input  logic [((8+SIZE_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // payload_byte [7:0], seq_number [23:8], rtp_timestamp [55:24]
  output logic [55:0]                               m_axis_tdata,
  // packet_first [0], packet_final [1]
  output logic [1:0]                                m_axis_tuser,
  output logic                                      m_axis_tlast,
  input  logic                                      cfg_we_i,
  input  logic                                      cfg_addr_i,
  input  logic [fua_pkg::CfgDataW-1:0]              cfg_data_i
);

  logic [fua_pkg::MaxPayloadW-1:0] max_payload_q;
  logic [fua_pkg::TsStepW-1:0]     ts_step_q;
  fua_pkg::fua_bundle_t            bundle;
  logic                            accept;
  logic [7:0]                      out_byte;
  logic                            out_first, out_final;
  logic [fua_pkg::SeqW-1:0]        out_seq;
  logic [fua_pkg::TsW-1:0]         out_ts;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= fua_pkg::MaxPayloadRst;
      ts_step_q     <= fua_pkg::TsStepRst;
    end else if (cfg_we_i) begin
      case (fua_pkg::cfg_idx_e'(cfg_addr_i))
        fua_pkg::CFG_MAX_PAYLOAD:    max_payload_q <= cfg_data_i[fua_pkg::MaxPayloadW-1:0];
        fua_pkg::CFG_TIMESTAMP_STEP: ts_step_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fua_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .nal_byte_i    (s_axis_tdata[7:0]),
    .nal_size_i    (s_axis_tdata[SIZE_BITS+7:8]),
    .max_payload_i (max_payload_q),
    .ts_step_i     (ts_step_q),
    .bundle_o      (bundle)
  );

  fua_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_first_o (out_first),
    .out_final_o (out_final),
    .out_seq_o   (out_seq),
    .out_ts_o    (out_ts),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_ts, out_seq, out_byte};
  assign m_axis_tuser = {out_final, out_first};

endmodule

// ----- hdl/fua_checker.sv -----
module fua_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic                     bound_q;
  logic [15:0]              seq_q;
  logic [31:0]              ts_q;
  logic                     beat;

  assign beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= 1'b1;
      seq_q   <= '0;
      ts_q    <= '0;
    end else if (beat) begin
      bound_q <= m_axis_tuser[1];
      seq_q   <= m_axis_tdata[23:8];
      ts_q    <= m_axis_tdata[55:24];
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_first_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && bound_q |-> m_axis_tuser[0])
    else $error("packet does not open with a first beat");

  a_seq_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !bound_q |-> (m_axis_tdata[23:8] == seq_q) && !m_axis_tuser[0])
    else $error("sequence number changed inside a packet");

  a_ts_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !bound_q |-> m_axis_tdata[55:24] == ts_q)
    else $error("timestamp changed inside a packet");

endmodule

bind h264_rtp_fu_a_packetizer fua_checker u_fua_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SizeW   = 20;
  localparam int unsigned WdLimit = 3000;

  typedef struct {
    logic [7:0]     pbyte;
    logic           first;
    logic           fin;
    logic [fua_pkg::SeqW-1:0] seq;
    logic [fua_pkg::TsW-1:0]  ts;
    logic           run_end;
  } rtp_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [fua_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // packetizer state mirror
  logic [fua_pkg::MaxPayloadW-1:0] lim_cfg;
  logic [fua_pkg::TsStepW-1:0]     ts_step_cfg;
  logic [SizeW-1:0]                unit_pos;
  logic [7:0]                      hdr_held;
  logic                            frag_on;
  logic [fua_pkg::MaxPayloadW-1:0] frag_fill;
  logic [fua_pkg::SeqW-1:0]        seq_cnt;
  logic [fua_pkg::TsW-1:0]         ts_acc;

  rtp_beat_t rtp_beats_due[$];

  int src_idle_pct = 33;
  int snk_idle_pct = 45;
  bit hold_off_req = 1'b0;
  int n_fail = 0;
  int n_bytes_in = 0;
  int n_beats_out = 0;
  int n_packets = 0;
  int n_frag_units = 0;
  int idle_cycles = 0;

  h264_rtp_fu_a_packetizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic push_beat(input logic [7:0] b, input logic first, input logic fin,
                           input logic run_end);
    rtp_beat_t e;
    e.pbyte   = b;
    e.first   = first;
    e.fin     = fin;
    e.seq     = seq_cnt;
    e.ts      = ts_acc;
    e.run_end = run_end;
    rtp_beats_due.push_back(e);
  endtask

  task automatic packetize_byte(input logic [7:0] b, input logic [SizeW-1:0] sz_in);
    logic [SizeW-1:0]                sz;
    logic [fua_pkg::MaxPayloadW-1:0] lim;
    logic                            unit_end;
    logic                            closes;
    logic [7:0]                      fu_hdr;
    sz  = (sz_in == '0) ? SizeW'(1) : sz_in;
    lim = (lim_cfg == '0) ? fua_pkg::MaxPayloadW'(1) : lim_cfg;
    unit_end = unit_pos >= sz - SizeW'(1);
    if (unit_pos == '0) begin
      hdr_held  = b;
      frag_on   = 32'(sz) > 32'(lim);
      frag_fill = '0;
      if (frag_on) n_frag_units++;
    end
    if (!frag_on) begin
      push_beat(b, unit_pos == '0, unit_end, 1'b1);
      if (unit_end) begin
        seq_cnt++;
        if (hdr_held[4:0] != fua_pkg::TypeSps && hdr_held[4:0] != fua_pkg::TypePps)
          ts_acc += 32'(ts_step_cfg);
      end
    end else if (unit_pos != '0) begin
      closes = unit_end || (32'(frag_fill) + 32'd1 >= 32'(lim));
      if (frag_fill == '0) begin
        push_beat((hdr_held & fua_pkg::FuNriMask) | fua_pkg::FuAType, 1'b1, 1'b0, 1'b0);
        fu_hdr = hdr_held & fua_pkg::NalTypeMask;
        if (unit_pos == SizeW'(1))
          fu_hdr |= fua_pkg::FuStart;
        else if (32'(sz) - 32'(unit_pos) <= 32'(lim))
          fu_hdr |= fua_pkg::FuEnd;
        push_beat(fu_hdr, 1'b0, 1'b0, 1'b0);
      end
      push_beat(b, 1'b0, closes, 1'b1);
      if (closes) begin
        seq_cnt++;
        frag_fill = '0;
      end else begin
        frag_fill++;
      end
      if (unit_end) ts_acc += 32'(ts_step_cfg);
    end
    if (unit_end) begin
      unit_pos  = '0;
      frag_on   = 1'b0;
      frag_fill = '0;
    end else begin
      unit_pos++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic [SizeW-1:0] sz);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, sz, b};
    do @(posedge clk_i); while (!s_axis_tready);
    packetize_byte(b, sz);
    n_bytes_in++;
  endtask

  // Noise bytes carry a random full-width size; the unit runs until it closes.
  task automatic send_unit(input logic [7:0] hdr, input int unsigned size, input int noise_pct);
    logic [SizeW-1:0] sz;
    bit               lead;
    lead = 1'b1;
    do begin
      sz = SizeW'(size);
      if ($urandom_range(99) < noise_pct) sz = SizeW'($urandom_range(20'hFFFFF, 0));
      send_byte(lead ? hdr : 8'($urandom_range(255)), sz);
      lead = 1'b0;
    end while (unit_pos != '0);
  endtask

  task automatic cfg_write(input fua_pkg::cfg_idx_e idx,
                           input logic [fua_pkg::CfgDataW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (rtp_beats_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fua_pkg::CFG_MAX_PAYLOAD) lim_cfg = val[fua_pkg::MaxPayloadW-1:0];
    else ts_step_cfg = val;
  endtask

  task automatic test_single_nal();
    send_byte(8'h67, 3);
    send_byte(8'h00, 3);
    send_byte(8'hFF, 3);
    send_byte(8'h68, 2);
    send_byte(8'h80, 2);
    send_byte(8'hFF, 0);
    send_byte(8'h00, 1);
  endtask

  task automatic test_fragmentation();
    cfg_write(fua_pkg::CFG_MAX_PAYLOAD, 16'd4);
    cfg_write(fua_pkg::CFG_TIMESTAMP_STEP, 16'hFFFF);
    send_byte(8'hFC, 10);
    send_byte(8'h00, 10);
    send_byte(8'hFF, 10);
    for (int i = 0; i < 7; i++) send_byte(8'($urandom_range(255)), 10);
    // only fragment: S set, E clear
    send_byte(8'h65, 5);
    for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)), 5);
  endtask

  task automatic test_zero_limit();
    cfg_write(fua_pkg::CFG_MAX_PAYLOAD, 16'd0);
    send_byte(8'h7C, 3);
    send_byte(8'hA5, 3);
    send_byte(8'h5A, 3);
    send_byte(8'h41, 1);
  endtask

  task automatic test_size_change();
    send_byte(8'h61, 20'hFFFFF);
    send_byte(8'h5A, 1);
  endtask

  task automatic test_limit_extremes();
    cfg_write(fua_pkg::CFG_MAX_PAYLOAD, 16'd4096);
    cfg_write(fua_pkg::CFG_TIMESTAMP_STEP, 16'd0);
    // units cut short by a smaller size on their second byte
    send_byte(8'h45, 4097);
    send_byte(8'hC3, 2);
    send_byte(8'h21, 4096);
    send_byte(8'h3C, 2);
    cfg_write(fua_pkg::CFG_MAX_PAYLOAD, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_unit(8'($urandom_range(255)), $urandom_range(12, 1), 0);
    cfg_write(fua_pkg::CFG_MAX_PAYLOAD, 16'd16);
    cfg_write(fua_pkg::CFG_TIMESTAMP_STEP, 16'hFFFF);
    send_unit(8'h41, 17, 0);
    send_unit(8'h27, 16, 0);
  endtask

  task automatic test_backpressure();
    cfg_write(fua_pkg::CFG_MAX_PAYLOAD, 16'd2);
    hold_off_req = 1'b1;
    send_unit(8'h5C, 40, 0);
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
    int          start;
    int          since_cfg;
    int unsigned lim;
    logic [7:0]  hdr;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = n_bytes_in;
    since_cfg = 1000;
    while (n_bytes_in - start < n_items) begin
      if (since_cfg >= 30) begin
        case ($urandom_range(4))
          0: lim = 0;
          1: lim = 1;
          2: lim = 16;
          default: lim = $urandom_range(24, 2);
        endcase
        cfg_write(fua_pkg::CFG_MAX_PAYLOAD, 16'(lim));
        case ($urandom_range(3))
          0: cfg_write(fua_pkg::CFG_TIMESTAMP_STEP, 16'd0);
          1: cfg_write(fua_pkg::CFG_TIMESTAMP_STEP, 16'hFFFF);
          default: cfg_write(fua_pkg::CFG_TIMESTAMP_STEP, 16'($urandom_range(16'hFFFF, 0)));
        endcase
        since_cfg = 0;
      end
      hdr = 8'($urandom_range(255));
      if ($urandom_range(4) == 0)
        hdr[4:0] = $urandom_range(1) ? fua_pkg::TypeSps : fua_pkg::TypePps;
      start = start + 0;
      since_cfg -= n_bytes_in;
      send_unit(hdr, $urandom_range((lim < 14) ? 3 * lim + 6 : 48, 1),
                ($urandom_range(9) == 0) ? 25 : 0);
      since_cfg += n_bytes_in;
    end
  endtask

  // receiver
  initial begin
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rtp_beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_beats_out++;
      if (m_axis_tuser[1]) n_packets++;
      if (rtp_beats_due.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected beat: tdata=%h tuser=%b tlast=%b",
                                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        e = rtp_beats_due.pop_front();
        if (m_axis_tdata[7:0] !== e.pbyte || m_axis_tdata[23:8] !== e.seq ||
            m_axis_tdata[55:24] !== e.ts || m_axis_tuser[0] !== e.first ||
            m_axis_tuser[1] !== e.fin || m_axis_tlast !== e.run_end) begin
          n_fail++;
          if (n_fail <= 10)
            $display("beat %0d: exp byte=%h seq=%h ts=%h first=%b final=%b last=%b",
                     n_beats_out, e.pbyte, e.seq, e.ts, e.first, e.fin, e.run_end,
                     "\n          got byte=%h seq=%h ts=%h first=%b final=%b last=%b",
                     m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tdata[55:24],
                     m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WdLimit) begin
        $display("timeout: no beat for %0d cycles, %0d beats outstanding",
                 WdLimit, rtp_beats_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    lim_cfg     = fua_pkg::MaxPayloadRst;
    ts_step_cfg = fua_pkg::TsStepRst;
    unit_pos    = '0;
    hdr_held    = '0;
    frag_on     = 1'b0;
    frag_fill   = '0;
    seq_cnt     = '0;
    ts_acc      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_nal();
    test_fragmentation();
    test_zero_limit();
    test_size_change();
    test_limit_extremes();
    test_backpressure();
    test_random_traffic(33, 45, 30);
    test_random_traffic(45, 33, 30);
    test_random_traffic(0, 0, 30);

    s_axis_tvalid <= 1'b0;
    while (rtp_beats_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d NAL bytes (%0d fragmented units); checked %0d beats in %0d packets",
             n_bytes_in, n_frag_units, n_beats_out, n_packets);
    $display("over payload limits 0..8191, timestamp steps 0..65535, stalls on both sides.");
    if (n_fail == 0 && rtp_beats_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d beats never seen", n_fail, rtp_beats_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fua_pkg.sv
hdl/fua_core.sv
hdl/fua_emit.sv
hdl/h264_rtp_fu_a_packetizer.sv
hdl/fua_checker.sv
dv/tb_top.sv
